// ----- sv/epoch_seconds_to_calendar_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the epoch-seconds to calendar unit
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ESC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/esc_pkg.sv -----
// ---------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and the month length table of the calendar unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

    // Year counter start and its residues modulo 4, 100 and 400.
    localparam logic [11:0] BaseYear    = 12'd1970;
    localparam logic [1:0]  BaseMod4    = 2'd2;
    localparam logic [6:0]  BaseMod100  = 7'd70;
    localparam logic [8:0]  BaseMod400  = 9'd370;

    // Reciprocals: x/15 = (x*Recip15)>>34 for x < 2^30, x/3 = (x*Recip3)>>33.
    localparam logic [31:0] Recip15 = 32'd1145324613;
    localparam logic [31:0] Recip3  = 32'd2863311531;

    // Division step selector.
    localparam logic [1:0] DIV_SEC  = 2'd0;
    localparam logic [1:0] DIV_MIN  = 2'd1;
    localparam logic [1:0] DIV_HOUR = 2'd2;

    localparam logic [3:0] LastMonth = 4'd11;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       fix;
        logic [1:0] div_sel;
        logic       year_step;
        logic       month_step;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_free;
    } t_status;

    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] len;
        case (mo)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- sv/esc_datapath.sv -----
// ---------------------------------------------------------------------------
// esc_datapath
// Reciprocal divider, year and month subtractors, hour offset and output
// register of the calendar unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  esc_pkg::t_cmd       i_cmd,
    output esc_pkg::t_status    o_status,
    input  logic [31:0]         i_epoch_seconds,
    input  logic signed [4:0]   i_zone_hour_offset,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [5:0]          o_second_of_minute,
    output logic [5:0]          o_minute_of_hour,
    output logic [4:0]          o_hour_of_day,
    output logic [4:0]          o_day_of_month,
    output logic [3:0]          o_month_of_year,
    output logic [11:0]         o_year_number
);

    logic [31:0] r_work;
    logic [63:0] r_prod;
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hr;
    logic [15:0] r_days;
    logic [11:0] r_year;
    logic [1:0]  r_m4;
    logic [6:0]  r_m100;
    logic [8:0]  r_m400;
    logic [3:0]  r_mo;
    logic        r_out_valid;
    logic [5:0]  r_o_sec;
    logic [5:0]  r_o_min;
    logic [4:0]  r_o_hr;
    logic [4:0]  r_o_day;
    logic [3:0]  r_o_mon;
    logic [11:0] r_o_year;

    logic        w_is_hour;
    logic [31:0] w_mul_x;
    logic [31:0] w_mul_k;
    logic [31:0] w_q;
    logic [31:0] w_qd;
    logic [31:0] w_rem;
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [4:0]  w_mlen;
    logic [6:0]  w_hsum;
    logic [4:0]  w_hout;

    assign w_is_hour = (i_cmd.div_sel == esc_pkg::DIV_HOUR);

    // Pre-shift the dividend so the remaining divisor is 15 or 3.
    assign w_mul_x = w_is_hour ? (r_work >> 3) : (r_work >> 2);
    assign w_mul_k = w_is_hour ? esc_pkg::Recip3 : esc_pkg::Recip15;

    assign w_q   = w_is_hour ? {1'b0, r_prod[63:33]} : {2'b0, r_prod[63:34]};
    assign w_qd  = w_is_hour ? ((w_q << 4) + (w_q << 3)) : ((w_q << 6) - (w_q << 2));
    assign w_rem = r_work - w_qd;

    assign w_leap = (r_m4 == 2'd0) && ((r_m100 != 7'd0) || (r_m400 == 9'd0));
    assign w_ylen = w_leap ? 9'd366 : 9'd365;
    assign w_mlen = esc_pkg::month_len(r_mo, w_leap);

    // hour + offset + 24 lies in 8..62; fold back into 0..23.
    assign w_hsum = 7'({2'b00, r_hr}) + 7'({{2{i_zone_hour_offset[4]}}, i_zone_hour_offset})
                    + 7'd24;
    always_comb begin
        if (w_hsum >= 7'd48) begin
            w_hout = 5'(w_hsum - 7'd48);
        end else if (w_hsum >= 7'd24) begin
            w_hout = 5'(w_hsum - 7'd24);
        end else begin
            w_hout = w_hsum[4:0];
        end
    end

    assign o_status.year_done  = (r_days < 16'(w_ylen));
    assign o_status.month_done = (r_mo == esc_pkg::LastMonth) || (r_days < 16'(w_mlen));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work <= i_epoch_seconds;
        end
        if (i_cmd.mul) begin
            r_prod <= w_mul_x * w_mul_k;
        end
        if (i_cmd.fix) begin
            r_work <= w_q;
            case (i_cmd.div_sel)
                esc_pkg::DIV_SEC: begin
                    r_sec <= w_rem[5:0];
                end
                esc_pkg::DIV_MIN: begin
                    r_min <= w_rem[5:0];
                end
                default: begin
                    r_hr   <= w_rem[4:0];
                    r_days <= w_q[15:0];
                    r_year <= esc_pkg::BaseYear;
                    r_m4   <= esc_pkg::BaseMod4;
                    r_m100 <= esc_pkg::BaseMod100;
                    r_m400 <= esc_pkg::BaseMod400;
                    r_mo   <= 4'd0;
                end
            endcase
        end
        // Drop one whole year while the day count still covers it.
        if (i_cmd.year_step && !o_status.year_done) begin
            r_days <= r_days - 16'(w_ylen);
            r_year <= r_year + 12'd1;
            r_m4   <= r_m4 + 2'd1;
            r_m100 <= (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
            r_m400 <= (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
        end
        if (i_cmd.month_step && !o_status.month_done) begin
            r_days <= r_days - 16'(w_mlen);
            r_mo   <= r_mo + 4'd1;
        end
        if (i_cmd.load_out) begin
            r_o_sec  <= r_sec;
            r_o_min  <= r_min;
            r_o_hr   <= w_hout;
            r_o_day  <= r_days[4:0] + 5'd1;
            r_o_mon  <= r_mo + 4'd1;
            r_o_year <= r_year;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_second_of_minute = r_o_sec;
    assign o_minute_of_hour   = r_o_min;
    assign o_hour_of_day      = r_o_hr;
    assign o_day_of_month     = r_o_day;
    assign o_month_of_year    = r_o_mon;
    assign o_year_number      = r_o_year;

endmodule

`default_nettype wire

// ----- sv/esc_ctrl.sv -----
// ---------------------------------------------------------------------------
// esc_ctrl
// Sequencer of the calendar unit: three divisions, year loop, month loop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  esc_pkg::t_status    i_status,
    output esc_pkg::t_cmd       o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_FIX   = 6'b000100,
        ST_YEAR  = 6'b001000,
        ST_MONTH = 6'b010000,
        ST_WRITE = 6'b100000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_div;
    logic [1:0] n_div;

    always_comb begin
        n_state = r_state;
        n_div   = r_div;
        o_cmd   = '0;
        o_cmd.div_sel = r_div;
        o_in_ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_div      = esc_pkg::DIV_SEC;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                if (r_div == esc_pkg::DIV_HOUR) begin
                    n_state = ST_YEAR;
                end else begin
                    n_div   = r_div + 2'd1;
                    n_state = ST_MUL;
                end
            end
            ST_YEAR: begin
                o_cmd.year_step = 1'b1;
                if (i_status.year_done) begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                o_cmd.month_step = 1'b1;
                if (i_status.month_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_div   <= esc_pkg::DIV_SEC;
        end else begin
            r_state <= n_state;
            r_div   <= n_div;
        end
    end

endmodule

`default_nettype wire

// ----- sv/epoch_seconds_to_calendar_unit.sv -----
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Converts a 32-bit seconds-since-1970 count into second, minute, zone
// shifted hour, day of month, month and Gregorian year.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   input     in         i_in_valid/o_in_ready  i_epoch_seconds
//   result    out        o_out_valid/i_out_ready six calendar fields
//   config    in         APB (psel..pready)     zone_hour_offset at 0x0
//
// A transaction runs three divisions, then a year loop over the Y (0..136)
// whole years passed and a month loop over the M (0..11) whole months in
// the final year, then writes the result. The year loop steps one year
// per cycle through its own subtractor.
// Reset clears the sequencer, the result valid flag and the zone offset.
// A held result does not block the next input; a finished result waits in
// the sequencer only while the output register is still occupied.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "epoch_seconds_to_calendar_unit_assert.svh"

module epoch_seconds_to_calendar_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transaction
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_epoch_seconds,
    // result transaction
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month_of_year,
    output logic [11:0] o_year_number,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    esc_pkg::t_cmd     w_cmd;
    esc_pkg::t_status  w_status;
    logic signed [4:0] r_zone_hour_offset;

    // The only register sits at byte 0; addresses with bit 2 set are unmapped.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_hour_offset <= 5'sd0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            // Keep the low five bits; they hold the two's complement offset.
            r_zone_hour_offset <= pwdata[4:0];
        end
    end

    // Return the register zero extended; unmapped reads return zero.
    assign prdata = paddr[2] ? 32'd0 : {27'd0, r_zone_hour_offset};

    esc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    esc_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_epoch_seconds    (i_epoch_seconds),
        .i_zone_hour_offset (r_zone_hour_offset),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_day_of_month     (o_day_of_month),
        .o_month_of_year    (o_month_of_year),
        .o_year_number      (o_year_number)
    );

    // An accepted input starts a conversion, so no second one is taken at once.
    `ESC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "ready after accept")
    // The output register is loaded only when it is free.
    `ESC_ASSERT_NOW(a_load_when_free, w_cmd.load_out, !o_out_valid || i_out_ready,
        "result overwritten")
    // Shifted hour always folds back into a day.
    `ESC_ASSERT_NOW(a_hour_range, o_out_valid, o_hour_of_day < 5'd24, "hour out of range")
    // Month and day loops never overrun.
    `ESC_ASSERT_NOW(a_month_range, o_out_valid,
        o_month_of_year != 4'd0 && o_month_of_year <= 4'd12 && o_day_of_month != 5'd0,
        "date out of range")

endmodule

`default_nettype wire
